[sv/tdca_pkg.sv]
// Package for the time-of-day counter with key adjustment.
// Holds the time and move types, operation and register codes, and reset constants.
// No dependencies; every other file of the block imports it.
package tdca_pkg;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [7:0] day;
    } time_t;

    typedef struct packed {
        logic       enable;
        logic       backward;
        logic [5:0] amount;
    } move_t;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POLL = 1'b1;

    localparam logic CFG_FAST_THRESHOLD = 1'b0;
    localparam logic CFG_FAST_STEP      = 1'b1;

    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [6:0] SEC_MOD  = 7'd60;
    localparam logic [6:0] MIN_MOD  = 7'd60;
    localparam logic [4:0] HOUR_MOD = 5'd24;

    localparam logic [7:0] THRESHOLD_RESET = 8'd250;
    localparam logic [5:0] STEP_RESET      = 6'd20;
    localparam logic [5:0] SEC_RESET       = 6'd5;
    localparam logic [5:0] MIN_RESET       = 6'd0;
    localparam logic [4:0] HOUR_RESET      = 5'd12;
    localparam logic [7:0] DAY_RESET       = 8'd0;
    localparam logic [7:0] SHOWN_RESET     = 8'd200;

endpackage

[sv/tdca_time_unit.sv]
// Next-time logic: moves the time forward or backward by up to 63 seconds.
// Carries and borrows ripple through minutes, hours and the day count.
// Depends on tdca_pkg for the time and move types and the wrap constants.
module tdca_time_unit (
    input  tdca_pkg::time_t cur,
    input  tdca_pkg::move_t mv,
    output tdca_pkg::time_t nxt
);
    import tdca_pkg::*;

    logic [6:0]        sec_sum;
    logic [5:0]        sec_a;
    logic [1:0]        carry;
    logic [6:0]        min_sum;
    logic [5:0]        min_a;
    logic              hour_carry;
    logic [4:0]        hour_sum;
    time_t             adv;

    logic signed [7:0] sec_diff;
    logic signed [7:0] sec_fix;
    logic [1:0]        borrow;
    logic signed [7:0] min_diff;
    logic signed [7:0] min_fix;
    logic              hour_borrow;
    time_t             ret;

    always_comb
    begin
        sec_sum = {1'b0, cur.sec} + {1'b0, mv.amount};
        if (sec_sum >= (SEC_MOD << 1))
        begin
            sec_a = 6'(sec_sum - (SEC_MOD << 1));
            carry = 2'd2;
        end
        else if (sec_sum >= SEC_MOD)
        begin
            sec_a = 6'(sec_sum - SEC_MOD);
            carry = 2'd1;
        end
        else
        begin
            sec_a = sec_sum[5:0];
            carry = 2'd0;
        end

        min_sum = {1'b0, cur.min} + {5'b0, carry};
        if (min_sum >= MIN_MOD)
        begin
            min_a      = 6'(min_sum - MIN_MOD);
            hour_carry = 1'b1;
        end
        else
        begin
            min_a      = min_sum[5:0];
            hour_carry = 1'b0;
        end

        hour_sum = cur.hour + {4'b0, hour_carry};
        adv.sec  = sec_a;
        adv.min  = min_a;
        if (hour_sum >= HOUR_MOD)
        begin
            adv.hour = hour_sum - HOUR_MOD;
            adv.day  = cur.day + 8'd1;
        end
        else
        begin
            adv.hour = hour_sum;
            adv.day  = cur.day;
        end
    end

    always_comb
    begin
        sec_diff = $signed({2'b0, cur.sec}) - $signed({2'b0, mv.amount});
        if (sec_diff < -$signed({1'b0, SEC_MOD}))
        begin
            sec_fix = sec_diff + $signed({1'b0, SEC_MOD} << 1);
            borrow  = 2'd2;
        end
        else if (sec_diff < 8'sd0)
        begin
            sec_fix = sec_diff + $signed({1'b0, SEC_MOD});
            borrow  = 2'd1;
        end
        else
        begin
            sec_fix = sec_diff;
            borrow  = 2'd0;
        end

        min_diff = $signed({2'b0, cur.min}) - $signed({6'b0, borrow});
        if (min_diff < 8'sd0)
        begin
            min_fix     = min_diff + $signed({1'b0, MIN_MOD});
            hour_borrow = 1'b1;
        end
        else
        begin
            min_fix     = min_diff;
            hour_borrow = 1'b0;
        end

        ret.sec = sec_fix[5:0];
        ret.min = min_fix[5:0];
        if (hour_borrow && (cur.hour == 5'd0))
        begin
            ret.hour = HOUR_MAX;
            ret.day  = cur.day - 8'd1;
        end
        else
        begin
            ret.hour = cur.hour - {4'b0, hour_borrow};
            ret.day  = cur.day;
        end
    end

    always_comb
    begin
        priority if (!mv.enable)
            nxt = cur;
        else if (mv.backward)
            nxt = ret;
        else
            nxt = adv;
    end

endmodule

[sv/time_of_day_counter_with_adjust.sv]
// Top level of the time-of-day counter with key adjustment.
// Holds the clock, key and configuration state and the output register.
// Depends on tdca_pkg and tdca_time_unit.
//
//  Channel   Signals                           Direction  Content
//  s_axis    s_tvalid s_tready s_tdata s_tuser  in        one tick or key poll word
//  m_axis    m_tvalid m_tready m_tdata         out       time and flags after the word
//  cfg       cfg_we cfg_index cfg_data         in        fast_threshold, fast_step
//
// Each word is worked out combinationally; its result appears in the output register
// on the next cycle. One word can be accepted per cycle, including while the
// result waits, provided the output register is free or taken in that cycle.
// A stalled output register holds s_tready low. Reset sets the clock state to
// 12:00:05, day 0, child-safe off; no clearing pass is needed.
module time_of_day_counter_with_adjust (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [0] key_forward, [1] key_backward, [2] key_mode
    input  logic        s_tuser,  // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [5:0] seconds, [11:6] minutes, [16:12] hours,
                                  // [24:17] day_count, [25] child_safe, [26] refresh
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import tdca_pkg::*;

    logic [7:0]  threshold_reg;
    logic [5:0]  step_reg;
    time_t       time_reg;
    time_t       time_next;
    logic [7:0]  shown_reg;
    logic [7:0]  shown_next;
    logic [7:0]  hold_reg;
    logic [7:0]  hold_next;
    logic        safe_reg;
    logic        safe_next;
    logic        refresh_next;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    move_t       mv;
    logic        accept;
    logic        poll;
    logic        key_fwd;
    logic        key_back;
    logic        key_mode;
    logic        fast;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign poll     = (s_tuser == OP_POLL);
    assign key_fwd  = s_tdata[0];
    assign key_back = s_tdata[1];
    assign key_mode = s_tdata[2];
    assign fast     = hold_reg > threshold_reg;

    always_comb
    begin
        mv.enable   = 1'b0;
        mv.backward = 1'b0;
        mv.amount   = 6'd1;
        hold_next   = hold_reg;
        safe_next   = safe_reg;
        if (!poll)
        begin
            mv.enable = 1'b1;
        end
        else if (key_fwd || key_back)
        begin
            mv.enable   = 1'b1;
            mv.backward = !key_fwd;
            if (fast)
                mv.amount = step_reg;
            else
                hold_next = hold_reg + 8'd1;
        end
        else if (key_mode)
        begin
            if (hold_reg == 8'd0)
            begin
                hold_next = 8'd1;
                safe_next = !safe_reg;
            end
        end
        else
        begin
            hold_next = 8'd0;
        end
    end

    tdca_time_unit u_time (
        .cur (time_reg),
        .mv  (mv),
        .nxt (time_next)
    );

    always_comb
    begin
        shown_next   = shown_reg;
        refresh_next = 1'b0;
        if (poll && ({2'b0, time_next.sec} != shown_reg))
        begin
            shown_next   = {2'b0, time_next.sec};
            refresh_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            step_reg      <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAST_THRESHOLD: threshold_reg <= cfg_data;
                CFG_FAST_STEP:      step_reg      <= cfg_data[5:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg.sec  <= SEC_RESET;
            time_reg.min  <= MIN_RESET;
            time_reg.hour <= HOUR_RESET;
            time_reg.day  <= DAY_RESET;
            shown_reg     <= SHOWN_RESET;
            hold_reg      <= 8'd0;
            safe_reg      <= 1'b0;
        end
        else if (accept)
        begin
            time_reg  <= time_next;
            shown_reg <= shown_next;
            hold_reg  <= hold_next;
            safe_reg  <= safe_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= {5'b0, refresh_next, safe_next, time_next.day,
                             time_next.hour, time_next.min, time_next.sec};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (time_reg.sec <= SEC_MAX) && (time_reg.min <= MIN_MAX) &&
        (time_reg.hour <= HOUR_MAX))
        else $error("time state out of range");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");

    a_tick_no_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_TICK)) |=> !m_tdata[26])
        else $error("tick reported a refresh");
`endif

endmodule

[tb/tb_time_of_day_counter_with_adjust.sv]
`timescale 1ns / 1ps
// Self-checking testbench for time_of_day_counter_with_adjust: directed table, then key presses.
// Depends on tdca_pkg and the block's RTL; holds its own time-of-day predictor.
module tb_time_of_day_counter_with_adjust;
    import tdca_pkg::*;

    typedef struct packed {
        logic op;
        logic fwd;
        logic back;
        logic mode;
    } key_word_t;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [7:0] day;
        logic       safe;
        logic       refresh;
    } clock_result_t;

    typedef struct packed {
        logic          is_cfg;
        logic          reg_index;
        logic [7:0]    reg_value;
        key_word_t     word;
        logic          typed;
        clock_result_t want;
    } stim_row_t;

    localparam logic ROW_WORD = 1'b0;
    localparam logic ROW_CFG  = 1'b1;
    localparam int QUIET_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [0] key_forward, [1] key_backward, [2] key_mode
    logic        s_tuser = 1'b0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [5:0] seconds, [11:6] minutes, [16:12] hours,
                                   // [24:17] day_count, [25] child_safe, [26] refresh
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;

    logic [7:0] fast_threshold = THRESHOLD_RESET;
    logic [5:0] fast_step      = STEP_RESET;
    logic [5:0] sec_cnt        = SEC_RESET;
    logic [5:0] min_cnt        = MIN_RESET;
    logic [4:0] hour_cnt       = HOUR_RESET;
    logic [7:0] day_cnt        = DAY_RESET;
    logic [7:0] shown_sec      = SHOWN_RESET;
    logic [7:0] hold_cnt       = 8'd0;
    logic       safe_mode      = 1'b0;

    clock_result_t expected_times[$];
    int mismatches = 0;
    int idle_pct = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    stim_row_t directed_rows [0:26] = '{
        '{ROW_WORD, 1'b0, 8'd0, {OP_TICK, 3'b000}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b00}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b000}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b01}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b000}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b00}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b001}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b10}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b001}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b10}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b111}, 1'b1, {6'd7, 6'd0, 5'd12, 8'd0, 2'b11}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b011}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b11}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b000}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b10}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b001}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b00}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_TICK, 3'b111}, 1'b1, {6'd7, 6'd0, 5'd12, 8'd0, 2'b00}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b010}, 1'b1, {6'd6, 6'd0, 5'd12, 8'd0, 2'b00}},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b000}, 1'b0, '0},
        '{ROW_CFG, CFG_FAST_THRESHOLD, 8'd0, {OP_TICK, 3'b000}, 1'b0, '0},
        '{ROW_CFG, CFG_FAST_STEP, 8'd0, {OP_TICK, 3'b000}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b100}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b100}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b010}, 1'b0, '0},
        '{ROW_CFG, CFG_FAST_STEP, 8'd63, {OP_TICK, 3'b000}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b010}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b100}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b110}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b000}, 1'b0, '0},
        '{ROW_CFG, CFG_FAST_THRESHOLD, 8'd255, {OP_TICK, 3'b000}, 1'b0, '0},
        '{ROW_CFG, CFG_FAST_STEP, 8'd59, {OP_TICK, 3'b000}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b010}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_POLL, 3'b100}, 1'b0, '0},
        '{ROW_WORD, 1'b0, 8'd0, {OP_TICK, 3'b000}, 1'b0, '0}
    };

    time_of_day_counter_with_adjust u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void add_seconds(input logic [5:0] amount);
        int unsigned total;
        int unsigned mins;
        int unsigned hrs;
        total    = sec_cnt + amount;
        mins     = min_cnt + total / 60;
        hrs      = hour_cnt + mins / 60;
        sec_cnt  = 6'(total % 60);
        min_cnt  = 6'(mins % 60);
        hour_cnt = 5'(hrs % 24);
        day_cnt  = day_cnt + 8'(hrs / 24);
    endfunction

    function automatic void sub_seconds(input logic [5:0] amount);
        repeat (amount)
        begin
            if (sec_cnt != 0)
                sec_cnt = sec_cnt - 6'd1;
            else
            begin
                sec_cnt = 6'd59;
                if (min_cnt != 0)
                    min_cnt = min_cnt - 6'd1;
                else
                begin
                    min_cnt = 6'd59;
                    if (hour_cnt != 0)
                        hour_cnt = hour_cnt - 5'd1;
                    else
                    begin
                        hour_cnt = 5'd23;
                        day_cnt  = day_cnt - 8'd1;
                    end
                end
            end
        end
    endfunction

    function automatic clock_result_t predict_clock(input key_word_t w);
        clock_result_t r;
        logic          fast;
        logic [5:0]    amount;
        r = '0;
        if (w.op == OP_TICK)
            add_seconds(6'd1);
        else
        begin
            if (w.fwd || w.back)
            begin
                fast   = hold_cnt > fast_threshold;
                amount = fast ? fast_step : 6'd1;
                if (!fast)
                    hold_cnt = hold_cnt + 8'd1;
                if (w.fwd)
                    add_seconds(amount);
                else
                    sub_seconds(amount);
            end
            else if (w.mode)
            begin
                // The flag toggles only on the first poll of a press.
                if (hold_cnt == 0)
                begin
                    hold_cnt  = 8'd1;
                    safe_mode = ~safe_mode;
                end
            end
            else
                hold_cnt = 8'd0;
            if ({2'b00, sec_cnt} != shown_sec)
            begin
                shown_sec = {2'b00, sec_cnt};
                r.refresh = 1'b1;
            end
        end
        r.sec  = sec_cnt;
        r.min  = min_cnt;
        r.hour = hour_cnt;
        r.day  = day_cnt;
        r.safe = safe_mode;
        return r;
    endfunction

    task automatic send_word(input key_word_t w, input logic typed, input clock_result_t want);
        clock_result_t predicted;
        int            gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {5'b00000, w.mode, w.back, w.fwd};
        do @(posedge clk); while (!s_tready);
        predicted = predict_clock(w);
        expected_times.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_times.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_FAST_THRESHOLD)
            fast_threshold = value;
        else
            fast_step = value[5:0];
    endtask

    // Presses are runs of polls holding one key pattern, with ticks mixed in and usually
    // a release poll at the end; the remainder of the picks are mode presses and noise.
    task automatic run_presses(input int n_words, input int fwd_pct, input int back_pct,
                               input int short_max, input int long_lo, input int long_hi,
                               input logic stop_on_day);
        int         sent;
        int         len;
        int         pick;
        logic [7:0] start_day;
        logic [2:0] keys;
        key_word_t  w;
        sent      = 0;
        start_day = day_cnt;
        while (sent < n_words && !(stop_on_day && day_cnt != start_day))
        begin
            pick   = $urandom_range(0, 99);
            w.op   = OP_POLL;
            w.fwd  = 1'($urandom_range(0, 1));
            w.back = 1'($urandom_range(0, 1));
            w.mode = 1'($urandom_range(0, 1));
            if (pick < fwd_pct)
                w.fwd = 1'b1;
            else if (pick < fwd_pct + back_pct)
            begin
                w.fwd  = 1'b0;
                w.back = 1'b1;
            end
            else if (pick < fwd_pct + back_pct + 10)
            begin
                w.fwd  = 1'b0;
                w.back = 1'b0;
                w.mode = 1'b1;
            end
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(long_lo, long_hi);
            else
                len = $urandom_range(1, short_max);
            repeat (len)
            begin
                keys = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0)
                    send_word({OP_TICK, keys}, 1'b0, '0);
                else
                    send_word(w, 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                send_word({OP_POLL, 3'b000}, 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0 && $urandom_range(0, 499) < idle_pct)
            stall_left = $urandom_range(1, 18);
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        clock_result_t got;
        clock_result_t want;
        if (m_tvalid && m_tready)
        begin
            got.sec     = m_tdata[5:0];
            got.min     = m_tdata[11:6];
            got.hour    = m_tdata[16:12];
            got.day     = m_tdata[24:17];
            got.safe    = m_tdata[25];
            got.refresh = m_tdata[26];
            if (expected_times.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %0d:%0d:%0d day %0d safe %0b refresh %0b",
                             got.hour, got.min, got.sec, got.day, got.safe, got.refresh);
            end
            else
            begin
                want = expected_times.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected %0d:%0d:%0d day %0d safe %0b refresh %0b,",
                                  " got %0d:%0d:%0d day %0d safe %0b refresh %0b"},
                                 want.hour, want.min, want.sec, want.day, want.safe,
                                 want.refresh, got.hour, got.min, got.sec, got.day,
                                 got.safe, got.refresh);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [7:0] value;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg == ROW_CFG)
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        end

        idle_pct = 25;
        value = 8'($urandom_range(0, 15));
        write_reg(CFG_FAST_THRESHOLD, value);
        write_reg(CFG_FAST_STEP, 8'd1);
        run_presses(80, 25, 55, 8, 16, 40, 1'b0);

        // A threshold of 255 can never be passed, so long presses wrap the hold count.
        idle_pct = 10;
        value = 8'($urandom_range(1, 59));
        write_reg(CFG_FAST_THRESHOLD, 8'd255);
        write_reg(CFG_FAST_STEP, value);
        run_presses(150, 70, 25, 8, 256, 300, 1'b0);

        // Run the time backward past midnight, then forward across it again.
        idle_pct = 15;
        write_reg(CFG_FAST_THRESHOLD, 8'd0);
        write_reg(CFG_FAST_STEP, 8'd63);
        run_presses(1100, 0, 92, 40, 40, 80, 1'b1);
        idle_pct = 30;
        write_reg(CFG_FAST_STEP, 8'd60);
        run_presses(40, 90, 5, 8, 8, 16, 1'b0);

        idle_pct = 25;
        value = 8'($urandom_range(0, 255));
        write_reg(CFG_FAST_THRESHOLD, value);
        value = 8'($urandom_range(0, 63));
        write_reg(CFG_FAST_STEP, value);
        run_presses(60, 40, 40, 8, 9, 30, 1'b0);

        write_reg(CFG_FAST_THRESHOLD, 8'd250);
        write_reg(CFG_FAST_STEP, 8'd20);
        idle_pct = 0;
        run_presses(60, 45, 45, 8, 245, 260, 1'b0);

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_times.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
